/* src/cdll_pkg.sv */
// Shared types and constants for the cursor doubly linked list
package cdll_pkg;

    localparam int POOL_DEPTH_DEF = 256;
    localparam int VALUE_BITS     = 32;
    localparam int IN_VALUE_BITS  = 32;
    localparam int OPCODE_BITS    = 3;
    localparam int STATUS_BITS    = 2;
    localparam int COUNT_BITS     = 9;

    localparam logic [OPCODE_BITS-1:0] OP_INS_BEFORE = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_INS_AFTER  = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_DELETE     = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_READ       = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_GO_HEAD    = 3'd4;
    localparam logic [OPCODE_BITS-1:0] OP_GO_TAIL    = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OPCODE_BITS-1:0]   opcode;
        logic [IN_VALUE_BITS-1:0] value;
    } cdll_cmd_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  current_value;
        logic                   has_current;
        logic [COUNT_BITS-1:0]  entry_count;
    } cdll_result_t;

    typedef struct packed {
        logic value_we;
        logic next_we;
        logic prev_we;
    } cdll_we_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_WRITE1,
        S_WRITE2,
        S_DONE
    } cdll_state_t;

endpackage

/* src/cdll_store.sv */
// Entry pool: value, next-link and prev-link memories with registered reads
module cdll_store #(
    parameter int POOL_DEPTH = cdll_pkg::POOL_DEPTH_DEF,
    parameter int AW         = $clog2(POOL_DEPTH),
    parameter int IW         = $clog2(POOL_DEPTH + 1)
) (
    input  logic                            clk,
    input  cdll_pkg::cdll_we_t              we,
    input  logic [AW-1:0]                   value_waddr,
    input  logic [cdll_pkg::VALUE_BITS-1:0] value_wdata,
    input  logic [AW-1:0]                   value_raddr,
    output logic [cdll_pkg::VALUE_BITS-1:0] value_rdata,
    input  logic [AW-1:0]                   next_waddr,
    input  logic [IW-1:0]                   next_wdata,
    input  logic [AW-1:0]                   next_raddr,
    output logic [IW-1:0]                   next_rdata,
    input  logic [AW-1:0]                   prev_waddr,
    input  logic [IW-1:0]                   prev_wdata,
    input  logic [AW-1:0]                   prev_raddr,
    output logic [IW-1:0]                   prev_rdata
);
    import cdll_pkg::*;

    logic [VALUE_BITS-1:0] value_mem [POOL_DEPTH];
    logic [IW-1:0]         next_mem  [POOL_DEPTH];
    logic [IW-1:0]         prev_mem  [POOL_DEPTH];

    logic [VALUE_BITS-1:0] value_rdata_reg;
    logic [IW-1:0]         next_rdata_reg;
    logic [IW-1:0]         prev_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we.value_we)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        value_rdata_reg <= value_mem[value_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rdata_reg <= next_mem[next_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rdata_reg <= prev_mem[prev_raddr];
    end

    assign value_rdata = value_rdata_reg;
    assign next_rdata  = next_rdata_reg;
    assign prev_rdata  = prev_rdata_reg;

endmodule

/* src/cdll_ctrl.sv */
// Sequencer and list registers: head, tail, cursor, free list, size
module cdll_ctrl #(
    parameter int POOL_DEPTH = cdll_pkg::POOL_DEPTH_DEF,
    parameter int AW         = $clog2(POOL_DEPTH),
    parameter int IW         = $clog2(POOL_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cdll_pkg::cdll_cmd_t             cmd,
    output logic                            done,
    output cdll_pkg::cdll_result_t          result,
    output cdll_pkg::cdll_we_t              we,
    output logic [AW-1:0]                   value_waddr,
    output logic [cdll_pkg::VALUE_BITS-1:0] value_wdata,
    output logic [AW-1:0]                   value_raddr,
    input  logic [cdll_pkg::VALUE_BITS-1:0] value_rdata,
    output logic [AW-1:0]                   next_waddr,
    output logic [IW-1:0]                   next_wdata,
    output logic [AW-1:0]                   next_raddr,
    input  logic [IW-1:0]                   next_rdata,
    output logic [AW-1:0]                   prev_waddr,
    output logic [IW-1:0]                   prev_wdata,
    output logic [AW-1:0]                   prev_raddr,
    input  logic [IW-1:0]                   prev_rdata
);
    import cdll_pkg::*;

    localparam logic [IW-1:0] NULL_IDX = IW'(POOL_DEPTH);

    cdll_state_t state_reg, state_next;

    logic [OPCODE_BITS-1:0] op_reg, op_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [IW-1:0]          head_reg, head_next;
    logic [IW-1:0]          tail_reg, tail_next;
    logic [IW-1:0]          cursor_reg, cursor_next;
    logic [IW-1:0]          free_reg, free_next;
    logic [IW-1:0]          fresh_reg, fresh_next;
    logic [IW-1:0]          size_reg, size_next;
    logic [IW-1:0]          e_reg, e_next;
    logic [IW-1:0]          cp_reg, cp_next;
    logic [IW-1:0]          cn_reg, cn_next;

    logic          from_free;
    logic          slot_ok;
    logic [IW-1:0] slot;
    logic          e_ok;
    logic          cp_ok;
    logic          cn_ok;
    logic          cur_ok;

    assign from_free = (free_reg < NULL_IDX);
    assign slot_ok   = from_free || (fresh_reg < NULL_IDX);
    assign slot      = from_free ? free_reg : fresh_reg;
    assign e_ok      = (e_reg < NULL_IDX);
    assign cp_ok     = (cp_reg < NULL_IDX);
    assign cn_ok     = (cn_reg < NULL_IDX);
    assign cur_ok    = (cursor_reg < NULL_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= NULL_IDX;
            tail_reg   <= NULL_IDX;
            cursor_reg <= NULL_IDX;
            free_reg   <= NULL_IDX;
            fresh_reg  <= '0;
            size_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
            free_reg   <= free_next;
            fresh_reg  <= fresh_next;
            size_reg   <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        e_reg      <= e_next;
        cp_reg     <= cp_next;
        cn_reg     <= cn_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        status_next = status_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cursor_next = cursor_reg;
        free_next   = free_reg;
        fresh_next  = fresh_reg;
        size_next   = size_reg;
        e_next      = e_reg;
        cp_next     = cp_reg;
        cn_next     = cn_reg;

        busy        = 1'b1;
        done        = 1'b0;
        we          = '0;
        value_waddr = slot[AW-1:0];
        value_wdata = val_reg;
        value_raddr = cursor_reg[AW-1:0];
        next_waddr  = slot[AW-1:0];
        next_wdata  = NULL_IDX;
        next_raddr  = cursor_reg[AW-1:0];
        prev_waddr  = slot[AW-1:0];
        prev_wdata  = NULL_IDX;
        prev_raddr  = cursor_reg[AW-1:0];

        case (state_reg)
            S_IDLE, S_DONE:
            begin
                busy = 1'b0;
                done = (state_reg == S_DONE);
                if (start)
                begin
                    op_next     = cmd.opcode;
                    val_next    = VALUE_BITS'(cmd.value);
                    status_next = ST_OK;
                    e_next      = cursor_reg;
                    state_next  = S_FETCH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // cursor links arrive; look up the free-list successor
            S_FETCH:
            begin
                cp_next    = prev_rdata;
                cn_next    = next_rdata;
                next_raddr = free_reg[AW-1:0];
                state_next = S_WRITE1;
            end

            S_WRITE1:
            begin
                state_next = S_WRITE2;
                if (op_reg inside {OP_INS_BEFORE, OP_INS_AFTER})
                begin
                    if (!slot_ok)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        we.value_we = 1'b1;
                        we.next_we  = 1'b1;
                        we.prev_we  = 1'b1;
                        if (!e_ok)
                        begin
                            head_next = slot;
                            tail_next = slot;
                        end
                        else if (op_reg == OP_INS_BEFORE)
                        begin
                            next_wdata = e_reg;
                            prev_wdata = cp_reg;
                            if (!cp_ok)
                            begin
                                head_next = slot;
                            end
                        end
                        else
                        begin
                            next_wdata = cn_reg;
                            prev_wdata = e_reg;
                            if (!cn_ok)
                            begin
                                tail_next = slot;
                            end
                        end
                        cursor_next = slot;
                        size_next   = size_reg + 1'b1;
                        if (from_free)
                        begin
                            free_next = next_rdata;
                        end
                        else
                        begin
                            fresh_next = fresh_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    case (op_reg)
                        OP_DELETE:
                        begin
                            if (!e_ok)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                if (cp_ok)
                                begin
                                    we.next_we  = 1'b1;
                                    next_waddr  = cp_reg[AW-1:0];
                                    next_wdata  = cn_reg;
                                    cursor_next = cp_reg;
                                end
                                else
                                begin
                                    cursor_next = cn_reg;
                                    head_next   = cn_reg;
                                end
                                if (cn_ok)
                                begin
                                    we.prev_we = 1'b1;
                                    prev_waddr = cn_reg[AW-1:0];
                                    prev_wdata = cp_reg;
                                end
                                else
                                begin
                                    tail_next = cp_reg;
                                end
                                if (size_reg != '0)
                                begin
                                    size_next = size_reg - 1'b1;
                                end
                            end
                        end
                        OP_GO_HEAD:
                        begin
                            cursor_next = head_reg;
                        end
                        OP_GO_TAIL:
                        begin
                            cursor_next = tail_reg;
                        end
                        default:
                        begin
                            cursor_next = cursor_reg;
                        end
                    endcase
                end
            end

            // neighbour fix-ups for inserts, free-list push for delete; value read at the final cursor
            S_WRITE2:
            begin
                state_next = S_DONE;
                if (status_reg == ST_OK)
                begin
                    case (op_reg)
                        OP_INS_BEFORE:
                        begin
                            if (e_ok)
                            begin
                                we.next_we = cp_ok;
                                next_waddr = cp_reg[AW-1:0];
                                next_wdata = cursor_reg;
                                we.prev_we = 1'b1;
                                prev_waddr = e_reg[AW-1:0];
                                prev_wdata = cursor_reg;
                            end
                        end
                        OP_INS_AFTER:
                        begin
                            if (e_ok)
                            begin
                                we.prev_we = cn_ok;
                                prev_waddr = cn_reg[AW-1:0];
                                prev_wdata = cursor_reg;
                                we.next_we = 1'b1;
                                next_waddr = e_reg[AW-1:0];
                                next_wdata = cursor_reg;
                            end
                        end
                        OP_DELETE:
                        begin
                            we.next_we = 1'b1;
                            next_waddr = e_reg[AW-1:0];
                            next_wdata = free_reg;
                            free_next  = e_reg;
                        end
                        default:
                        begin
                            we = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.status        = status_reg;
        result.has_current   = cur_ok;
        result.current_value = cur_ok ? value_rdata : '0;
        result.entry_count   = COUNT_BITS'(size_reg);
    end

endmodule

/* src/cursor_doubly_linked_list.sv */
// Cursor doubly linked list, top level
// Sequence: after the accepting edge the sequencer passes through fetch (links
// arrive), the first and second write states and the done state, in which done is
// high and the result word is valid; a new word may be accepted in the done state,
// not before. The steps follow from the registered link reads and the single write
// port on each link memory. The receiver cannot stall.
// Reset: list empty, cursor null, no pool entry used; memories are not cleared.
module cursor_doubly_linked_list #(
    parameter int POOL_DEPTH = cdll_pkg::POOL_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  cdll_pkg::cdll_cmd_t    cmd,
    output logic                   done,
    output cdll_pkg::cdll_result_t result
);
    import cdll_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int IW = $clog2(POOL_DEPTH + 1);

    cdll_we_t              we;
    logic [AW-1:0]         value_waddr;
    logic [VALUE_BITS-1:0] value_wdata;
    logic [AW-1:0]         value_raddr;
    logic [VALUE_BITS-1:0] value_rdata;
    logic [AW-1:0]         next_waddr;
    logic [IW-1:0]         next_wdata;
    logic [AW-1:0]         next_raddr;
    logic [IW-1:0]         next_rdata;
    logic [AW-1:0]         prev_waddr;
    logic [IW-1:0]         prev_wdata;
    logic [AW-1:0]         prev_raddr;
    logic [IW-1:0]         prev_rdata;

    cdll_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .IW         (IW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .we          (we),
        .value_waddr (value_waddr),
        .value_wdata (value_wdata),
        .value_raddr (value_raddr),
        .value_rdata (value_rdata),
        .next_waddr  (next_waddr),
        .next_wdata  (next_wdata),
        .next_raddr  (next_raddr),
        .next_rdata  (next_rdata),
        .prev_waddr  (prev_waddr),
        .prev_wdata  (prev_wdata),
        .prev_raddr  (prev_raddr),
        .prev_rdata  (prev_rdata)
    );

    cdll_store #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .IW         (IW)
    ) u_store (
        .clk         (clk),
        .we          (we),
        .value_waddr (value_waddr),
        .value_wdata (value_wdata),
        .value_raddr (value_raddr),
        .value_rdata (value_rdata),
        .next_waddr  (next_waddr),
        .next_wdata  (next_wdata),
        .next_raddr  (next_raddr),
        .next_rdata  (next_rdata),
        .prev_waddr  (prev_waddr),
        .prev_wdata  (prev_wdata),
        .prev_raddr  (prev_raddr),
        .prev_rdata  (prev_rdata)
    );

endmodule
